FILE: hw/rtl/pfde_pkg.sv
package pfde_pkg;

    // Command codes on i_action
    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_PIXEL = 3'd1;
    localparam logic [2:0] ACT_HLINE = 3'd2;
    localparam logic [2:0] ACT_VLINE = 3'd3;
    localparam logic [2:0] ACT_RECT  = 3'd4;
    localparam logic [2:0] ACT_FILL  = 3'd5;
    localparam logic [2:0] ACT_FLUSH = 3'd6;

    // Result kinds on o_kind
    localparam logic [1:0] KIND_DRAW  = 2'd0;
    localparam logic [1:0] KIND_CHUNK = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Widest column index (256 columns) and row index (64 rows)
    localparam int COL_MAX_W = 8;
    localparam int ROW_MAX_W = 6;

    // Flush column counter: at most 16 chunks of 8 columns
    localparam int FCOL_W = 7;

    // Clipped box: inclusive column and row bounds
    typedef struct packed {
        logic                 empty;
        logic [COL_MAX_W-1:0] col_first;
        logic [COL_MAX_W-1:0] col_last;
        logic [ROW_MAX_W-1:0] row_first;
        logic [ROW_MAX_W-1:0] row_last;
    } t_clip;

    // Bits lo..hi of a page byte set
    function automatic logic [7:0] row_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] m;
        m = (8'hff << lo) & (8'hff >> (3'd7 - hi));
        return m;
    endfunction

endpackage

FILE: hw/rtl/pfde_store.sv
module pfde_store #(
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [(1 << AW)];
    logic [7:0] r_rd_data;

    // Write one byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/pfde_box_clip.sv
module pfde_box_clip #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_ROWS    = 64
) (
    input  logic signed [11:0] i_bx,
    input  logic signed [11:0] i_by,
    input  logic signed [9:0]  i_bw,
    input  logic signed [9:0]  i_bh,
    output pfde_pkg::t_clip    o_clip
);

    localparam logic signed [12:0] COL_LIM = 13'(SCREEN_COLUMNS);
    localparam logic signed [12:0] ROW_LIM = 13'(SCREEN_ROWS);

    logic signed [12:0] ex;
    logic signed [12:0] ey;
    logic signed [12:0] x0;
    logic signed [12:0] y0;
    logic signed [12:0] x1;
    logic signed [12:0] y1;

    // Clamp the box to the screen on half-open bounds, then output inclusive bounds
    always_comb begin
        ex = 13'(i_bx) + 13'(i_bw);
        ey = 13'(i_by) + 13'(i_bh);
        x0 = (i_bx < 12'sd0) ? 13'sd0 : 13'(i_bx);
        y0 = (i_by < 12'sd0) ? 13'sd0 : 13'(i_by);
        x1 = (ex > COL_LIM) ? COL_LIM : ex;
        y1 = (ey > ROW_LIM) ? ROW_LIM : ey;
        o_clip.empty     = (i_bw <= 10'sd0) || (i_bh <= 10'sd0) || (x0 >= x1) || (y0 >= y1);
        o_clip.col_first = pfde_pkg::COL_MAX_W'(x0);
        o_clip.col_last  = pfde_pkg::COL_MAX_W'(x1 - 13'sd1);
        o_clip.row_first = pfde_pkg::ROW_MAX_W'(y0);
        o_clip.row_last  = pfde_pkg::ROW_MAX_W'(y1 - 13'sd1);
    end

endmodule

FILE: hw/rtl/page_framebuffer_draw_engine_core.sv
// Monochrome page framebuffer with per-page dirty bits.
// Command channel: present i_action and operands with start; the command is
// transferred at a clock edge where start is high and busy is low. busy stays
// high until the command's work is done.
// Result channel: each result sits on the o_ ports for one cycle with o_strobe
// high; the receiver cannot stall it. o_last marks the final result.
// Draw commands walk the clipped box one column byte per cycle through a
// read-modify-write on the single byte store: setup, one step per byte (one
// empty step if the box clips to nothing), drain; a rectangle outline runs
// four boxes back to back. After the last box's drain, the done step
// registers the one result. Clear sweeps every store entry, one a cycle
// (1024 entries at the default size). Flush reads one column byte a cycle
// and emits a chunk per 8 columns, up to 16 chunks of the lowest dirty page;
// a flush with no dirty page answers with an empty result.
// Reset: a clearing pass over all 2^(page bits + column bits) entries (1024
// by default) zeroes the store; busy is high during it and the dirty bits are 0.
module page_framebuffer_draw_engine_core #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int PAGE_COUNT     = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_action,
    input  logic signed [9:0] i_pos_x,
    input  logic signed [9:0] i_pos_y,
    input  logic signed [9:0] i_span_w,
    input  logic signed [9:0] i_span_h,
    input  logic              i_pixel_on,
    output logic              o_strobe,
    output logic [1:0]        o_kind,
    output logic [2:0]        o_page_index,
    output logic [3:0]        o_chunk_index,
    output logic [63:0]       o_chunk_data,
    output logic [7:0]        o_dirty_mask,
    output logic              o_last
);

    localparam int CW     = $clog2(SCREEN_COLUMNS);
    localparam int PGW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int AW     = PGW + CW;
    localparam int CHUNKS = ((SCREEN_COLUMNS + 7) / 8 > 16) ? 16 : (SCREEN_COLUMNS + 7) / 8;
    localparam logic [pfde_pkg::FCOL_W-1:0] FCOL_END = pfde_pkg::FCOL_W'(CHUNKS * 8 - 1);
    localparam logic [8:0] COL_LIM   = 9'(SCREEN_COLUMNS);
    localparam logic [7:0] ALL_PAGES = 8'((1 << PAGE_COUNT) - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SWEEP = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_RUN   = 8'b0000_1000,
        S_DRAIN = 8'b0001_0000,
        S_FLUSH = 8'b0010_0000,
        S_FEND  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [2:0]                  r_act;
    logic signed [9:0]           r_x;
    logic signed [9:0]           r_y;
    logic signed [9:0]           r_w;
    logic signed [9:0]           r_h;
    logic                        r_on;
    logic [1:0]                  r_box;
    logic [1:0]                  r_nbox;
    pfde_pkg::t_clip             r_clip;
    pfde_pkg::t_clip             clip_out;
    logic [PGW-1:0]              r_page;
    logic [CW-1:0]               r_col;
    logic [AW-1:0]               r_sweep;
    logic                        r_sweep_cmd;
    logic [7:0]                  r_dirty;
    logic                        r_wr_pend;
    logic [AW-1:0]               r_wr_addr;
    logic [7:0]                  r_wr_mask;
    logic [PGW-1:0]              r_wr_page;
    logic [pfde_pkg::FCOL_W-1:0] r_fcol;
    logic                        r_fl_pend;
    logic                        r_fl_zero;
    logic [pfde_pkg::FCOL_W-1:0] r_fl_col;
    logic [63:0]                 r_acc;
    logic [1:0]                  r_done_kind;
    logic                        r_out_strobe;
    logic [1:0]                  r_out_kind;
    logic [2:0]                  r_out_page;
    logic [3:0]                  r_out_chunk;
    logic [63:0]                 r_out_data;
    logic [7:0]                  r_out_dirty;
    logic                        r_out_last;

    logic                        accept;
    logic signed [11:0]          bx;
    logic signed [11:0]          by;
    logic signed [9:0]           bw;
    logic signed [9:0]           bh;
    logic [PGW-1:0]              pg_first;
    logic [PGW-1:0]              pg_last;
    logic [2:0]                  bit_lo;
    logic [2:0]                  bit_hi;
    logic [7:0]                  run_mask;
    logic                        draw_rd;
    logic                        flush_rd;
    logic                        col_in_range;
    logic                        sweep_we;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [7:0]                  mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [7:0]                  mem_rdata;
    logic [7:0]                  new_byte;
    logic [7:0]                  fl_byte;
    logic                        any_dirty;
    logic [PGW-1:0]              low_dirty;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Pick the box of the current command
    always_comb begin
        bx = 12'(r_x);
        by = 12'(r_y);
        bw = r_w;
        bh = r_h;
        unique case (r_act) inside
            pfde_pkg::ACT_PIXEL: begin
                bw = 10'sd1;
                bh = 10'sd1;
            end
            pfde_pkg::ACT_HLINE: begin
                bh = 10'sd1;
            end
            pfde_pkg::ACT_VLINE: begin
                bw = 10'sd1;
            end
            pfde_pkg::ACT_RECT: begin
                case (r_box)
                    2'd0: bh = 10'sd1;
                    2'd1: begin
                        by = 12'(r_y) + 12'(r_h) - 12'sd1;
                        bh = 10'sd1;
                    end
                    2'd2: bw = 10'sd1;
                    default: begin
                        bx = 12'(r_x) + 12'(r_w) - 12'sd1;
                        bw = 10'sd1;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    pfde_box_clip #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (PAGE_COUNT * 8)
    ) u_clip (
        .i_bx   (bx),
        .i_by   (by),
        .i_bw   (bw),
        .i_bh   (bh),
        .o_clip (clip_out)
    );

    // Row mask of the page under the walk
    always_comb begin
        pg_first = PGW'(r_clip.row_first[5:3]);
        pg_last  = PGW'(r_clip.row_last[5:3]);
        bit_lo   = (r_page == pg_first) ? r_clip.row_first[2:0] : 3'd0;
        bit_hi   = (r_page == pg_last) ? r_clip.row_last[2:0] : 3'd7;
        run_mask = pfde_pkg::row_mask(bit_lo, bit_hi);
    end

    // Lowest dirty page
    always_comb begin
        any_dirty = |(r_dirty & ALL_PAGES);
        low_dirty = '0;
        for (int p = PAGE_COUNT - 1; p >= 0; p--) begin
            if (r_dirty[p]) begin
                low_dirty = PGW'(p);
            end
        end
    end

    // Store port steering
    always_comb begin
        col_in_range = ({2'b00, r_fcol} < COL_LIM);
        draw_rd      = (r_state == S_RUN) && !r_clip.empty;
        flush_rd     = (r_state == S_FLUSH) && col_in_range;
        sweep_we     = (r_state == S_SWEEP);
        mem_re       = draw_rd || flush_rd;
        mem_raddr    = draw_rd ? {r_page, r_col} : {r_page, CW'(r_fcol)};
        new_byte     = r_on ? (mem_rdata | r_wr_mask) : (mem_rdata & ~r_wr_mask);
        mem_we       = sweep_we || r_wr_pend;
        mem_waddr    = sweep_we ? r_sweep : r_wr_addr;
        mem_wdata    = sweep_we ? 8'h00 : new_byte;
        fl_byte      = r_fl_zero ? 8'h00 : mem_rdata;
    end

    pfde_store #(
        .AW (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action) inside
                        pfde_pkg::ACT_CLEAR: n_state = S_SWEEP;
                        pfde_pkg::ACT_PIXEL, pfde_pkg::ACT_HLINE,
                        pfde_pkg::ACT_VLINE, pfde_pkg::ACT_FILL: n_state = S_SETUP;
                        pfde_pkg::ACT_RECT: begin
                            n_state = ((i_span_w > 10'sd0) && (i_span_h > 10'sd0))
                                    ? S_SETUP : S_DONE;
                        end
                        pfde_pkg::ACT_FLUSH: n_state = any_dirty ? S_FLUSH : S_DONE;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SWEEP: begin
                if (r_sweep == '1) begin
                    n_state = r_sweep_cmd ? S_DONE : S_IDLE;
                end
            end
            S_SETUP: n_state = S_RUN;
            S_RUN: begin
                if (r_clip.empty) begin
                    n_state = S_DRAIN;
                end else if ((r_col == CW'(r_clip.col_last)) && (r_page == pg_last)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = (r_box == r_nbox) ? S_DONE : S_SETUP;
            S_FLUSH: begin
                if (r_fcol == FCOL_END) begin
                    n_state = S_FEND;
                end
            end
            S_FEND: n_state = S_IDLE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep      <= '0;
            r_sweep_cmd  <= 1'b0;
            r_dirty      <= 8'h00;
            r_wr_pend    <= 1'b0;
            r_fl_pend    <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            // Strobe on the done step and on each full flush chunk
            r_out_strobe <= (r_state == S_DONE) || (r_fl_pend && (r_fl_col[2:0] == 3'd7));
            r_wr_pend    <= draw_rd;
            r_fl_pend    <= (r_state == S_FLUSH);

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act       <= i_action;
                        r_x         <= i_pos_x;
                        r_y         <= i_pos_y;
                        r_w         <= i_span_w;
                        r_h         <= i_span_h;
                        r_on        <= i_pixel_on;
                        r_box       <= 2'd0;
                        r_nbox      <= (i_action == pfde_pkg::ACT_RECT) ? 2'd3 : 2'd0;
                        r_done_kind <= pfde_pkg::KIND_DRAW;
                        r_sweep     <= '0;
                        r_sweep_cmd <= 1'b1;
                        r_fcol      <= '0;
                        if (i_action == pfde_pkg::ACT_FLUSH) begin
                            if (any_dirty) begin
                                r_page  <= low_dirty;
                                r_dirty <= r_dirty & ~(8'h01 << low_dirty);
                            end else begin
                                r_done_kind <= pfde_pkg::KIND_EMPTY;
                            end
                        end
                    end
                end
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if ((r_sweep == '1) && r_sweep_cmd) begin
                        r_dirty <= ALL_PAGES;
                    end
                end
                S_SETUP: begin
                    r_clip <= clip_out;
                    r_page <= PGW'(clip_out.row_first[5:3]);
                    r_col  <= CW'(clip_out.col_first);
                end
                S_RUN: begin
                    // Advance column, wrap to next page at the right edge
                    if (r_col == CW'(r_clip.col_last)) begin
                        r_col  <= CW'(r_clip.col_first);
                        r_page <= r_page + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_box <= r_box + 1'b1;
                end
                S_FLUSH: begin
                    r_fcol <= r_fcol + 1'b1;
                end
                S_FEND: begin
                end
                S_DONE: begin
                    r_out_kind   <= r_done_kind;
                    r_out_page   <= 3'd0;
                    r_out_chunk  <= 4'd0;
                    r_out_data   <= 64'd0;
                    r_out_dirty  <= r_dirty;
                    r_out_last   <= 1'b1;
                end
                default: begin
                end
            endcase

            // Finish the read-modify-write; mark the page on a real change
            if (r_wr_pend && (new_byte != mem_rdata)) begin
                r_dirty <= r_dirty | (8'h01 << r_wr_page);
            end

            // Collect flush bytes and transfer each full chunk
            if (r_fl_pend) begin
                r_acc <= {fl_byte, r_acc[63:8]};
                if (r_fl_col[2:0] == 3'd7) begin
                    r_out_kind   <= pfde_pkg::KIND_CHUNK;
                    r_out_page   <= 3'(r_page);
                    r_out_chunk  <= r_fl_col[6:3];
                    r_out_data   <= {fl_byte, r_acc[63:8]};
                    r_out_dirty  <= r_dirty;
                    r_out_last   <= (r_fl_col == FCOL_END);
                end
            end
        end
    end

    // Payload of the byte under update and of the flush read in flight
    always_ff @(posedge i_clk) begin
        r_wr_addr <= {r_page, r_col};
        r_wr_mask <= run_mask;
        r_wr_page <= r_page;
        r_fl_zero <= !col_in_range;
        r_fl_col  <= r_fcol;
    end

    assign o_strobe      = r_out_strobe;
    assign o_kind        = r_out_kind;
    assign o_page_index  = r_out_page;
    assign o_chunk_index = r_out_chunk;
    assign o_chunk_data  = r_out_data;
    assign o_dirty_mask  = r_out_dirty;
    assign o_last        = r_out_last;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    a_chunk_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == pfde_pkg::KIND_CHUNK)) |-> !o_dirty_mask[o_page_index])
        else $error("flushed page still marked dirty");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sweep_we && r_wr_pend))
        else $error("sweep write collides with pixel update");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result follows the final result directly");
`endif

endmodule
